/* rtl/core/obb_osa_pkg.sv */
// Shared types, constants and helpers for the oriented-box overlap tester.
// No dependencies; imported by every module of the block.
package obb_osa_pkg;

  // Request kind codes
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TEST = 1'b1
  } kind_e;

  // Saturating arithmetic works on 64-bit signed values bounded by +-(2^62 - 1)
  typedef logic signed [63:0] sat_t;

  localparam logic [62:0] SAT_MAX = 63'h3FFF_FFFF_FFFF_FFFF;
  localparam sat_t        SAT_POS = {1'b0, SAT_MAX};
  localparam sat_t        SAT_NEG = -SAT_POS;

  // Three reference faces, three target faces, nine cross products
  localparam int unsigned NUM_FACE  = 3;
  localparam int unsigned NUM_CROSS = 9;
  localparam int unsigned NUM_LANES = 2 * NUM_FACE + NUM_CROSS;
  localparam int unsigned NUM_BOXAX = 2 * NUM_FACE;

  // Saturating add of two bounded values
  function automatic sat_t sat_add(sat_t a, sat_t b);
    sat_t s;
    s = a + b;
    if (s > SAT_POS) return SAT_POS;
    if (s < SAT_NEG) return SAT_NEG;
    return s;
  endfunction

  // Lane map: lanes 0-2 reference faces, 3-5 target faces, 6-14 cross (i*3+j)
  function automatic bit lane_a_face(int n);
    return n < 3;
  endfunction

  function automatic bit lane_b_face(int n);
    return (n >= 3) && (n < 6);
  endfunction

  // Face lane: index of the own face; otherwise axis left out (3 = none)
  function automatic int lane_a_sel(int n);
    if (n < 3) return n;
    if (n < 6) return 3;
    return (n - 6) / 3;
  endfunction

  function automatic int lane_b_sel(int n);
    if (n < 3) return 3;
    if (n < 6) return n - 3;
    return (n - 6) % 3;
  endfunction

endpackage

/* rtl/core/obb_osa_req_if.sv */
// Request channel of the overlap tester: valid/ready plus one box.
// No dependencies.
interface obb_osa_req_if #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned AXIS_WIDTH  = 16,
  parameter int unsigned TAG_WIDTH   = 16
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic [3*AXIS_WIDTH-1:0]       axis_u;
  logic [3*AXIS_WIDTH-1:0]       axis_v;
  logic [3*AXIS_WIDTH-1:0]       axis_w;
  logic [COORD_WIDTH-2:0]        half_u;
  logic [COORD_WIDTH-2:0]        half_v;
  logic [COORD_WIDTH-2:0]        half_w;
  logic [TAG_WIDTH-1:0]          tag;

  modport source (
    output valid, kind, center_x, center_y, center_z, axis_u, axis_v, axis_w,
           half_u, half_v, half_w, tag,
    input  ready
  );
  modport sink (
    input  valid, kind, center_x, center_y, center_z, axis_u, axis_v, axis_w,
           half_u, half_v, half_w, tag,
    output ready
  );
endinterface

/* rtl/core/obb_osa_res_if.sv */
// Result channel of the overlap tester: valid/ready, hit flag and tag.
// No dependencies.
interface obb_osa_res_if #(
  parameter int unsigned TAG_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [TAG_WIDTH-1:0] hit_tag;

  modport source (output valid, hit, hit_tag, input ready);
  modport sink (input valid, hit, hit_tag, output ready);
endinterface

/* rtl/core/obb_osa_front.sv */
// Front stages: reference store, input register, centre delta, cross-product axes.
// Depends on obb_osa_pkg.
module obb_osa_front
  import obb_osa_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned AXIS_WIDTH  = 16,
  parameter int unsigned TAG_WIDTH   = 16,
  localparam int unsigned HW   = COORD_WIDTH - 1,
  localparam int unsigned DW   = COORD_WIDTH + 1,
  localparam int unsigned DIRW = AXIS_WIDTH + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          kind_i,
  input  logic signed [COORD_WIDTH-1:0] c_i   [3],
  input  logic [3*AXIS_WIDTH-1:0]       ax_i  [3],
  input  logic [HW-1:0]                 h_i   [3],
  input  logic [TAG_WIDTH-1:0]          tag_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [DIRW-1:0]        dir_o [NUM_LANES][3],
  output logic signed [DW-1:0]          dd_o  [3],
  output logic [3*AXIS_WIDTH-1:0]       aax_o [3],
  output logic [3*AXIS_WIDTH-1:0]       bax_o [3],
  output logic [HW-1:0]                 ah_o  [3],
  output logic [HW-1:0]                 bh_o  [3],
  output logic [TAG_WIDTH-1:0]          tag_o
);

  localparam int unsigned AW = AXIS_WIDTH;
  localparam int unsigned F  = AXIS_WIDTH - 2;
  localparam int unsigned PW = 2 * AXIS_WIDTH;

  // Reference box
  logic signed [COORD_WIDTH-1:0] ref_c_q  [3];
  logic [3*AW-1:0]               ref_ax_q [3];
  logic [HW-1:0]                 ref_h_q  [3];

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic load;

  // Stage 1: snapshot of the reference plus the target
  logic signed [COORD_WIDTH-1:0] s1_ac_q [3], s1_bc_q [3];
  logic [3*AW-1:0]               s1_aax_q [3], s1_bax_q [3];
  logic [HW-1:0]                 s1_ah_q [3], s1_bh_q [3];
  logic [TAG_WIDTH-1:0]          s1_tag_q;

  // Stage 2: centre delta and cross partial products
  logic signed [PW-1:0]  px_d [NUM_CROSS][3], py_d [NUM_CROSS][3];
  logic signed [PW-1:0]  s2_px_q [NUM_CROSS][3], s2_py_q [NUM_CROSS][3];
  logic signed [DW-1:0]  dd_d [3], s2_dd_q [3];
  logic [3*AW-1:0]       s2_aax_q [3], s2_bax_q [3];
  logic [HW-1:0]         s2_ah_q [3], s2_bh_q [3];
  logic [TAG_WIDTH-1:0]  s2_tag_q;

  // Stage 3: fifteen test directions
  logic signed [DIRW-1:0] dir_d [NUM_LANES][3], s3_dir_q [NUM_LANES][3];
  logic signed [DW-1:0]   s3_dd_q [3];
  logic [3*AW-1:0]        s3_aax_q [3], s3_bax_q [3];
  logic [HW-1:0]          s3_ah_q [3], s3_bh_q [3];
  logic [TAG_WIDTH-1:0]   s3_tag_q;

  // Stall chain: a stage moves when it is empty or its successor moves
  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign load    = valid_i && rdy1 && (kind_i == KIND_LOAD);

  // Reference store, written by load requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        ref_c_q[k]  <= '0;
        ref_ax_q[k] <= '0;
        ref_h_q[k]  <= '0;
      end
    end else if (load) begin
      ref_c_q  <= c_i;
      ref_ax_q <= ax_i;
      ref_h_q  <= h_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i && (kind_i == KIND_TEST);
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Centre delta
  for (genvar k = 0; k < 3; k++) begin : g_dd
    assign dd_d[k] = DW'(s1_ac_q[k]) - DW'(s1_bc_q[k]);
  end

  // Cross partial products: comp k = a[k1]*b[k2] - a[k2]*b[k1]
  for (genvar c = 0; c < NUM_CROSS; c++) begin : g_xc
    for (genvar k = 0; k < 3; k++) begin : g_xk
      localparam int I  = c / 3;
      localparam int J  = c % 3;
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      assign px_d[c][k] = PW'($signed(s1_aax_q[I][K1*AW +: AW]))
                        * PW'($signed(s1_bax_q[J][K2*AW +: AW]));
      assign py_d[c][k] = PW'($signed(s1_aax_q[I][K2*AW +: AW]))
                        * PW'($signed(s1_bax_q[J][K1*AW +: AW]));
    end
  end

  // Directions: face axes as given, cross axes truncated toward zero by F bits
  for (genvar n = 0; n < NUM_LANES; n++) begin : g_dir
    for (genvar k = 0; k < 3; k++) begin : g_dk
      if (n < 3) begin : g_fa
        assign dir_d[n][k] = DIRW'($signed(s2_aax_q[n][k*AW +: AW]));
      end else if (n < 6) begin : g_fb
        assign dir_d[n][k] = DIRW'($signed(s2_bax_q[n-3][k*AW +: AW]));
      end else begin : g_cr
        logic signed [PW:0]  raw;
        logic [PW:0]         rmag;
        logic [DIRW-1:0]     sh;
        assign raw  = (PW+1)'(s2_px_q[n-6][k]) - (PW+1)'(s2_py_q[n-6][k]);
        assign rmag = raw[PW] ? -raw : raw;
        assign sh   = rmag[PW:F];
        assign dir_d[n][k] = raw[PW] ? -$signed(sh) : $signed(sh);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_ac_q  <= ref_c_q;
      s1_aax_q <= ref_ax_q;
      s1_ah_q  <= ref_h_q;
      s1_bc_q  <= c_i;
      s1_bax_q <= ax_i;
      s1_bh_q  <= h_i;
      s1_tag_q <= tag_i;
    end
    if (rdy2) begin
      s2_px_q  <= px_d;
      s2_py_q  <= py_d;
      s2_dd_q  <= dd_d;
      s2_aax_q <= s1_aax_q;
      s2_bax_q <= s1_bax_q;
      s2_ah_q  <= s1_ah_q;
      s2_bh_q  <= s1_bh_q;
      s2_tag_q <= s1_tag_q;
    end
    if (rdy3) begin
      s3_dir_q <= dir_d;
      s3_dd_q  <= s2_dd_q;
      s3_aax_q <= s2_aax_q;
      s3_bax_q <= s2_bax_q;
      s3_ah_q  <= s2_ah_q;
      s3_bh_q  <= s2_bh_q;
      s3_tag_q <= s2_tag_q;
    end
  end

  assign dir_o = s3_dir_q;
  assign dd_o  = s3_dd_q;
  assign aax_o = s3_aax_q;
  assign bax_o = s3_bax_q;
  assign ah_o  = s3_ah_q;
  assign bh_o  = s3_bh_q;
  assign tag_o = s3_tag_q;

endmodule

/* rtl/core/obb_osa_proj.sv */
// Projection stages: axis dot products, saturated radius terms, delta projection.
// Depends on obb_osa_pkg.
module obb_osa_proj
  import obb_osa_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned AXIS_WIDTH  = 16,
  parameter int unsigned TAG_WIDTH   = 16,
  localparam int unsigned HW   = COORD_WIDTH - 1,
  localparam int unsigned DW   = COORD_WIDTH + 1,
  localparam int unsigned DIRW = AXIS_WIDTH + 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [DIRW-1:0] dir_i [NUM_LANES][3],
  input  logic signed [DW-1:0]   dd_i  [3],
  input  logic [3*AXIS_WIDTH-1:0] aax_i [3],
  input  logic [3*AXIS_WIDTH-1:0] bax_i [3],
  input  logic [HW-1:0]          ah_i  [3],
  input  logic [HW-1:0]          bh_i  [3],
  input  logic [TAG_WIDTH-1:0]   tag_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [62:0]            tm_o  [NUM_LANES][NUM_BOXAX],
  output logic [62:0]            hf_o  [NUM_BOXAX],
  output sat_t                   l1_o  [NUM_LANES],
  output sat_t                   lt2_o [NUM_LANES],
  output logic [TAG_WIDTH-1:0]   tag_o
);

  localparam int unsigned AW  = AXIS_WIDTH;
  localparam int unsigned F   = AXIS_WIDTH - 2;
  localparam int unsigned UPW = AW + DIRW;
  localparam int unsigned SW  = UPW + 2;
  localparam int unsigned UW  = SW - F;
  localparam int unsigned LPW = DW + DIRW;
  localparam int unsigned LMW = (LPW > 63) ? LPW : 63;
  localparam int unsigned TPW = HW + UW;
  localparam int unsigned TMW = (TPW > 63) ? TPW : 63;
  localparam int unsigned FPW = HW + F;
  localparam int unsigned FMW = (FPW > 63) ? FPW : 63;

  logic v4_q, v5_q, v6_q;
  logic rdy4, rdy5, rdy6;

  logic [HW-1:0] h_in [NUM_BOXAX];

  // Stage 4: component products
  logic signed [UPW-1:0] up_d [NUM_LANES][NUM_BOXAX][3];
  logic signed [UPW-1:0] s4_up_q [NUM_LANES][NUM_BOXAX][3];
  logic signed [LPW-1:0] lp_d [NUM_LANES][3], s4_lp_q [NUM_LANES][3];
  logic [HW-1:0]         s4_h_q [NUM_BOXAX];
  logic [TAG_WIDTH-1:0]  s4_tag_q;

  // Stage 5: |u.d| >> F and saturated delta terms
  logic [UW-1:0]         ud_d [NUM_LANES][NUM_BOXAX], s5_ud_q [NUM_LANES][NUM_BOXAX];
  sat_t                  lt_d [NUM_LANES][3], s5_lt_q [NUM_LANES][3];
  logic [HW-1:0]         s5_h_q [NUM_BOXAX];
  logic [TAG_WIDTH-1:0]  s5_tag_q;

  // Stage 6: radius terms, own-face radii, first partial projection
  logic [62:0]           tm_d [NUM_LANES][NUM_BOXAX], s6_tm_q [NUM_LANES][NUM_BOXAX];
  logic [62:0]           hf_d [NUM_BOXAX], s6_hf_q [NUM_BOXAX];
  sat_t                  l1_d [NUM_LANES], s6_l1_q [NUM_LANES];
  sat_t                  s6_lt2_q [NUM_LANES];
  logic [TAG_WIDTH-1:0]  s6_tag_q;

  assign rdy6    = !v6_q || ready_i;
  assign rdy5    = !v5_q || rdy6;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;
  assign valid_o = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  for (genvar m = 0; m < 3; m++) begin : g_hin
    assign h_in[m]   = ah_i[m];
    assign h_in[m+3] = bh_i[m];
  end

  for (genvar n = 0; n < NUM_LANES; n++) begin : g_ln
    // Products of every box axis and of the delta with this direction
    for (genvar k = 0; k < 3; k++) begin : g_k
      logic [LPW-1:0] lmag;
      logic [LMW-1:0] lext;
      logic [62:0]    lsat;
      for (genvar m = 0; m < NUM_BOXAX; m++) begin : g_m
        if (m < 3) begin : g_a
          assign up_d[n][m][k] = UPW'($signed(aax_i[m][k*AW +: AW])) * UPW'(dir_i[n][k]);
        end else begin : g_b
          assign up_d[n][m][k] = UPW'($signed(bax_i[m-3][k*AW +: AW])) * UPW'(dir_i[n][k]);
        end
      end
      assign lp_d[n][k] = LPW'(dd_i[k]) * LPW'(dir_i[n][k]);

      // Saturate the delta term, keep its sign
      assign lmag = s4_lp_q[n][k][LPW-1] ? -s4_lp_q[n][k] : s4_lp_q[n][k];
      assign lext = LMW'(lmag);
      assign lsat = (lext > LMW'(SAT_MAX)) ? SAT_MAX : lext[62:0];
      assign lt_d[n][k] = s4_lp_q[n][k][LPW-1] ? -sat_t'({1'b0, lsat}) : sat_t'({1'b0, lsat});
    end

    for (genvar m = 0; m < NUM_BOXAX; m++) begin : g_ud
      logic signed [SW-1:0] sum;
      logic [SW-1:0]        smag;
      logic [TPW-1:0]       tp;
      logic [TMW-1:0]       text;
      assign sum  = SW'(s4_up_q[n][m][0]) + SW'(s4_up_q[n][m][1]) + SW'(s4_up_q[n][m][2]);
      assign smag = sum[SW-1] ? -sum : sum;
      assign ud_d[n][m] = smag[SW-1:F];

      // half length times projected cosine, saturated
      assign tp   = TPW'(s5_h_q[m]) * TPW'(s5_ud_q[n][m]);
      assign text = TMW'(tp);
      assign tm_d[n][m] = (text > TMW'(SAT_MAX)) ? SAT_MAX : text[62:0];
    end

    assign l1_d[n] = sat_add(s5_lt_q[n][0], s5_lt_q[n][1]);
  end

  // Own-face radius: half length times one, saturated
  for (genvar m = 0; m < NUM_BOXAX; m++) begin : g_hf
    logic [FPW-1:0] fp;
    logic [FMW-1:0] fext;
    assign fp   = FPW'(s5_h_q[m]) << F;
    assign fext = FMW'(fp);
    assign hf_d[m] = (fext > FMW'(SAT_MAX)) ? SAT_MAX : fext[62:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_up_q  <= up_d;
      s4_lp_q  <= lp_d;
      s4_h_q   <= h_in;
      s4_tag_q <= tag_i;
    end
    if (rdy5) begin
      s5_ud_q  <= ud_d;
      s5_lt_q  <= lt_d;
      s5_h_q   <= s4_h_q;
      s5_tag_q <= s4_tag_q;
    end
    if (rdy6) begin
      s6_tm_q  <= tm_d;
      s6_hf_q  <= hf_d;
      s6_l1_q  <= l1_d;
      for (int n = 0; n < NUM_LANES; n++) s6_lt2_q[n] <= s5_lt_q[n][2];
      s6_tag_q <= s5_tag_q;
    end
  end

  assign tm_o  = s6_tm_q;
  assign hf_o  = s6_hf_q;
  assign l1_o  = s6_l1_q;
  assign lt2_o = s6_lt2_q;
  assign tag_o = s6_tag_q;

endmodule

/* rtl/core/obb_osa_sep.sv */
// Decision stages: radii per axis, final projection, separation test, result register.
// Depends on obb_osa_pkg.
module obb_osa_sep
  import obb_osa_pkg::*;
#(
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [62:0]          tm_i  [NUM_LANES][NUM_BOXAX],
  input  logic [62:0]          hf_i  [NUM_BOXAX],
  input  sat_t                 l1_i  [NUM_LANES],
  input  sat_t                 lt2_i [NUM_LANES],
  input  logic [TAG_WIDTH-1:0] tag_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic                 hit_o,
  output logic [TAG_WIDTH-1:0] hit_tag_o
);

  logic v7_q, v8_q;
  logic rdy7, rdy8;

  logic [62:0]          ra_d [NUM_LANES], rb_d [NUM_LANES];
  logic [62:0]          s7_ra_q [NUM_LANES], s7_rb_q [NUM_LANES];
  sat_t                 l2_d [NUM_LANES], s7_l2_q [NUM_LANES];
  logic [TAG_WIDTH-1:0] s7_tag_q;

  logic [NUM_LANES-1:0] sep;
  logic                 hit_d;
  logic                 hit_q;
  logic [TAG_WIDTH-1:0] tag_q;

  assign rdy8    = !v8_q || ready_i;
  assign rdy7    = !v7_q || rdy8;
  assign ready_o = rdy7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (rdy7) v7_q <= valid_i;
      if (rdy8) v8_q <= v7_q;
    end
  end

  for (genvar n = 0; n < NUM_LANES; n++) begin : g_ln
    localparam int ASEL = lane_a_sel(n);
    localparam int BSEL = lane_b_sel(n);

    logic [63:0] rs;
    logic [62:0] rsc;
    sat_t        labs;

    // Reference radius: own face, or sum over the axes taken
    if (lane_a_face(n)) begin : g_af
      assign ra_d[n] = hf_i[ASEL];
    end else begin : g_as
      logic [63:0] sa;
      assign sa = {1'b0, (ASEL != 0) ? tm_i[n][0] : 63'd0}
                + {1'b0, (ASEL != 1) ? tm_i[n][1] : 63'd0}
                + {1'b0, (ASEL != 2) ? tm_i[n][2] : 63'd0};
      assign ra_d[n] = (sa > {1'b0, SAT_MAX}) ? SAT_MAX : sa[62:0];
    end

    // Target radius
    if (lane_b_face(n)) begin : g_bf
      assign rb_d[n] = hf_i[3+BSEL];
    end else begin : g_bs
      logic [63:0] sb;
      assign sb = {1'b0, (BSEL != 0) ? tm_i[n][3] : 63'd0}
                + {1'b0, (BSEL != 1) ? tm_i[n][4] : 63'd0}
                + {1'b0, (BSEL != 2) ? tm_i[n][5] : 63'd0};
      assign rb_d[n] = (sb > {1'b0, SAT_MAX}) ? SAT_MAX : sb[62:0];
    end

    assign l2_d[n] = sat_add(l1_i[n], lt2_i[n]);

    // Separating when |L| exceeds the saturated radius sum
    assign rs   = {1'b0, s7_ra_q[n]} + {1'b0, s7_rb_q[n]};
    assign rsc  = (rs > {1'b0, SAT_MAX}) ? SAT_MAX : rs[62:0];
    assign labs = s7_l2_q[n][63] ? -s7_l2_q[n] : s7_l2_q[n];
    assign sep[n] = labs[62:0] > rsc;
  end

  assign hit_d = ~|sep;

  always_ff @(posedge clk_i) begin
    if (rdy7) begin
      s7_ra_q  <= ra_d;
      s7_rb_q  <= rb_d;
      s7_l2_q  <= l2_d;
      s7_tag_q <= tag_i;
    end
    if (rdy8) begin
      hit_q <= hit_d;
      tag_q <= s7_tag_q;
    end
  end

  assign valid_o   = v8_q;
  assign hit_o     = hit_q;
  assign hit_tag_o = tag_q;

endmodule

/* rtl/core/obb_overlap_separating_axis_core.sv */
// Oriented-box overlap tester, top level: request/result channels and stage chain.
// Depends on obb_osa_pkg, obb_osa_req_if, obb_osa_res_if, obb_osa_front,
// obb_osa_proj and obb_osa_sep.
//
// Usage: requests arrive on req_i (valid/ready). A request of kind load
// stores its box as the reference at once and yields no result. A request
// of kind test is checked against the reference held when it was taken, on
// 15 separating axes, and yields one result on res_o: hit (boxes overlap)
// and the request's tag. Results leave in request order.
// Eight register stages. Throughput: one request per cycle while res_o
// does not stall, set by the fully pipelined stage chain (one set of
// multipliers per axis lane).
// Reset clears all valid bits and the reference box to the all-zero box.
// When res_o stalls, the result register holds and stages behind it fill
// up; req_i.ready stays high while any empty stage can still absorb a
// request, so bubbles are squeezed out and nothing is lost or repeated.
module obb_overlap_separating_axis_core
  import obb_osa_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned AXIS_WIDTH  = 16,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  obb_osa_req_if.sink    req_i,
  obb_osa_res_if.source  res_o
);

  localparam int unsigned HW   = COORD_WIDTH - 1;
  localparam int unsigned DW   = COORD_WIDTH + 1;
  localparam int unsigned DIRW = AXIS_WIDTH + 3;

  logic signed [COORD_WIDTH-1:0] c_in  [3];
  logic [3*AXIS_WIDTH-1:0]       ax_in [3];
  logic [HW-1:0]                 h_in  [3];

  // Front to projection
  logic                   fp_valid, fp_ready;
  logic signed [DIRW-1:0] dir   [NUM_LANES][3];
  logic signed [DW-1:0]   dd    [3];
  logic [3*AXIS_WIDTH-1:0] aax  [3], bax [3];
  logic [HW-1:0]          ah    [3], bh [3];
  logic [TAG_WIDTH-1:0]   fp_tag;

  // Projection to decision
  logic                   ps_valid, ps_ready;
  logic [62:0]            tm    [NUM_LANES][NUM_BOXAX];
  logic [62:0]            hf    [NUM_BOXAX];
  sat_t                   l1    [NUM_LANES];
  sat_t                   lt2   [NUM_LANES];
  logic [TAG_WIDTH-1:0]   ps_tag;

  assign c_in[0]  = req_i.center_x;
  assign c_in[1]  = req_i.center_y;
  assign c_in[2]  = req_i.center_z;
  assign ax_in[0] = req_i.axis_u;
  assign ax_in[1] = req_i.axis_v;
  assign ax_in[2] = req_i.axis_w;
  assign h_in[0]  = req_i.half_u;
  assign h_in[1]  = req_i.half_v;
  assign h_in[2]  = req_i.half_w;

  obb_osa_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .AXIS_WIDTH (AXIS_WIDTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(req_i.valid),
    .ready_o(req_i.ready),
    .kind_i (req_i.kind),
    .c_i    (c_in),
    .ax_i   (ax_in),
    .h_i    (h_in),
    .tag_i  (req_i.tag),
    .valid_o(fp_valid),
    .ready_i(fp_ready),
    .dir_o  (dir),
    .dd_o   (dd),
    .aax_o  (aax),
    .bax_o  (bax),
    .ah_o   (ah),
    .bh_o   (bh),
    .tag_o  (fp_tag)
  );

  obb_osa_proj #(
    .COORD_WIDTH(COORD_WIDTH),
    .AXIS_WIDTH (AXIS_WIDTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(fp_valid),
    .ready_o(fp_ready),
    .dir_i  (dir),
    .dd_i   (dd),
    .aax_i  (aax),
    .bax_i  (bax),
    .ah_i   (ah),
    .bh_i   (bh),
    .tag_i  (fp_tag),
    .valid_o(ps_valid),
    .ready_i(ps_ready),
    .tm_o   (tm),
    .hf_o   (hf),
    .l1_o   (l1),
    .lt2_o  (lt2),
    .tag_o  (ps_tag)
  );

  obb_osa_sep #(
    .TAG_WIDTH(TAG_WIDTH)
  ) u_sep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ps_valid),
    .ready_o  (ps_ready),
    .tm_i     (tm),
    .hf_i     (hf),
    .l1_i     (l1),
    .lt2_i    (lt2),
    .tag_i    (ps_tag),
    .valid_o  (res_o.valid),
    .ready_i  (res_o.ready),
    .hit_o    (res_o.hit),
    .hit_tag_o(res_o.hit_tag)
  );

endmodule

/* rtl/core/obb_osa_checker.sv */
// Port-level checks for the overlap tester, bound to the top level.
// Depends on obb_osa_pkg and obb_overlap_separating_axis_core.
module obb_osa_checker
  import obb_osa_pkg::*;
#(
  parameter int unsigned TAG_WIDTH = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid_i,
  input logic                 req_ready_i,
  input logic                 req_kind_i,
  input logic [TAG_WIDTH-1:0] req_tag_i,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input logic                 res_hit_i,
  input logic [TAG_WIDTH-1:0] res_tag_i
);

  logic test_acc;
  assign test_acc = req_valid_i && req_ready_i && (req_kind_i == KIND_TEST);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_hit_i) && $stable(res_tag_i))
    else $error("stalled result changed");

  // With the result register free or draining, a request is always taken
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!res_valid_i || res_ready_i) |-> req_ready_i)
    else $error("request refused while pipeline can move");

  // Unstalled pipe: a taken test request yields a result with the matching tag
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_acc ##1 res_ready_i ##1 res_ready_i ##1 res_ready_i ##1 res_ready_i
      ##1 res_ready_i ##1 res_ready_i ##1 res_ready_i
    |=> res_valid_i && (res_tag_i == $past(req_tag_i, 8)))
    else $error("result missing or tag mismatch");

  // No result once reset has taken effect
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !res_valid_i)
    else $error("result valid during reset");

endmodule

bind obb_overlap_separating_axis_core obb_osa_checker #(
  .TAG_WIDTH(TAG_WIDTH)
) u_obb_osa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .req_kind_i (req_i.kind),
  .req_tag_i  (req_i.tag),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .res_hit_i  (res_o.hit),
  .res_tag_i  (res_o.hit_tag)
);

/* dv/tb_obb_overlap_separating_axis_core.sv */
// Testbench for the oriented-box overlap tester: directed table then random boxes.
// Depends on obb_osa_pkg, obb_osa_req_if, obb_osa_res_if and the core itself.
// Each result is checked against a local 15-axis separation predictor or a table's expected hit.
`timescale 1ns / 100ps

module tb_obb_overlap_separating_axis_core;
  import obb_osa_pkg::*;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned AXIS_WIDTH  = 16;
  localparam int unsigned TAG_WIDTH   = 16;
  localparam int          FRAC        = AXIS_WIDTH - 2;
  localparam int          NUM_RANDOM  = 1230;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [AXIS_WIDTH-1:0] ONE_AX = 16'h4000;
  localparam logic [AXIS_WIDTH-1:0] DIAG   = 16'h2D41;  // cos 45 deg in Q2.14

  typedef struct {
    kind_e                   kind;
    logic [COORD_WIDTH-1:0]  cx, cy, cz;
    logic [3*AXIS_WIDTH-1:0] au, av, aw;
    logic [COORD_WIDTH-2:0]  hu, hv, hw;
    logic [TAG_WIDTH-1:0]    tag;
    bit                      typed;    // expected hit given in the table
    bit                      typed_hit;
  } box_req_t;

  typedef struct {
    bit                   hit;
    logic [TAG_WIDTH-1:0] tag;
  } hit_rec_t;

  typedef struct {
    longint c[3];
    longint ax[3][3];
    longint h[3];
  } box_t;

  typedef longint vec3_t[3];

  logic clk_i = 1'b0;
  logic rst_ni;

  obb_osa_req_if #(.COORD_WIDTH(COORD_WIDTH), .AXIS_WIDTH(AXIS_WIDTH),
                   .TAG_WIDTH(TAG_WIDTH)) req_if ();
  obb_osa_res_if #(.TAG_WIDTH(TAG_WIDTH)) res_if ();

  obb_overlap_separating_axis_core #(
    .COORD_WIDTH(COORD_WIDTH), .AXIS_WIDTH(AXIS_WIDTH), .TAG_WIDTH(TAG_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Reference box as the predictor sees it
  logic [COORD_WIDTH-1:0]  ref_c [3];
  logic [3*AXIS_WIDTH-1:0] ref_ax[3];
  logic [COORD_WIDTH-2:0]  ref_h [3];

  hit_rec_t  hit_q[$];
  box_req_t  cur;          // request on the bus, updated with NBA
  box_req_t  table_q[$];
  int        errors = 0;
  int        sent = 0;
  int        cycles = 0;
  bit        calm = 1'b0;  // no idling on either side
  bit        squeeze = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic longint smul(longint a, longint b);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p  = pa * pb;
    if (p > SAT_POS) return SAT_POS;
    if (p < SAT_NEG) return SAT_NEG;
    return longint'(p);
  endfunction

  function automatic longint sadd(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SAT_POS) return SAT_POS;
    if (s < SAT_NEG) return SAT_NEG;
    return s;
  endfunction

  // Cosine magnitude of an axis against a direction, Q.F
  function automatic longint cosine(vec3_t u, vec3_t d);
    longint s;
    s = u[0] * d[0] + u[1] * d[1] + u[2] * d[2];
    if (s < 0) s = -s;
    return s >>> FRAC;
  endfunction

  function automatic longint box_radius(box_t b, vec3_t d, int skip);
    longint r;
    vec3_t  a;
    r = 0;
    for (int k = 0; k < 3; k++) begin
      if (k != skip) begin
        a = b.ax[k];
        r = sadd(r, smul(b.h[k], cosine(a, d)));
      end
    end
    return r;
  endfunction

  function automatic bit splits(vec3_t dc, vec3_t d, longint ra, longint rb);
    longint l;
    l = 0;
    for (int k = 0; k < 3; k++) l = sadd(l, smul(dc[k], d[k]));
    if (l < 0) l = -l;
    return l > sadd(ra, rb);
  endfunction

  function automatic longint rtz(longint x);
    if (x < 0) return -((-x) >>> FRAC);
    return x >>> FRAC;
  endfunction

  function automatic box_t unpack_box(logic [COORD_WIDTH-1:0] c[3],
                                      logic [3*AXIS_WIDTH-1:0] ax[3],
                                      logic [COORD_WIDTH-2:0] h[3]);
    box_t b;
    for (int i = 0; i < 3; i++) begin
      b.c[i] = longint'($signed(c[i]));
      b.h[i] = longint'(h[i]);
      for (int k = 0; k < 3; k++)
        b.ax[i][k] = longint'($signed(ax[i][k*AXIS_WIDTH +: AXIS_WIDTH]));
    end
    return b;
  endfunction

  function automatic bit boxes_overlap(box_t a, box_t b);
    vec3_t  dc, d, p, q;
    longint one;
    one = longint'(1) << FRAC;
    for (int i = 0; i < 3; i++) dc[i] = a.c[i] - b.c[i];
    // reference faces
    for (int i = 0; i < 3; i++) begin
      d = a.ax[i];
      if (splits(dc, d, smul(a.h[i], one), box_radius(b, d, 3))) return 1'b0;
    end
    // target faces
    for (int j = 0; j < 3; j++) begin
      d = b.ax[j];
      if (splits(dc, d, box_radius(a, d, 3), smul(b.h[j], one))) return 1'b0;
    end
    // edge cross products
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p = a.ax[i];
        q = b.ax[j];
        d[0] = rtz(p[1] * q[2] - p[2] * q[1]);
        d[1] = rtz(p[2] * q[0] - p[0] * q[2]);
        d[2] = rtz(p[0] * q[1] - p[1] * q[0]);
        if (splits(dc, d, box_radius(a, d, i), box_radius(b, d, j))) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Taken requests: load the reference or queue the expected hit
  always @(posedge clk_i or negedge rst_ni) begin
    logic [COORD_WIDTH-1:0]  tc[3];
    logic [3*AXIS_WIDTH-1:0] ta[3];
    logic [COORD_WIDTH-2:0]  th[3];
    hit_rec_t                rec;
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        ref_c[k]  = '0;
        ref_ax[k] = '0;
        ref_h[k]  = '0;
      end
    end else if (req_if.valid && req_if.ready) begin
      tc = '{cur.cx, cur.cy, cur.cz};
      ta = '{cur.au, cur.av, cur.aw};
      th = '{cur.hu, cur.hv, cur.hw};
      if (cur.kind == KIND_LOAD) begin
        ref_c  = tc;
        ref_ax = ta;
        ref_h  = th;
      end else begin
        rec.tag = cur.tag;
        rec.hit = cur.typed ? cur.typed_hit
                : boxes_overlap(unpack_box(ref_c, ref_ax, ref_h), unpack_box(tc, ta, th));
        hit_q = {hit_q, rec};
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    hit_rec_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (hit_q.size() == 0) begin
        $display("%0t: result with nothing pending: hit %0b tag %h",
                 $time, res_if.hit, res_if.hit_tag);
        errors++;
      end else begin
        want = hit_q.pop_front();
        if (res_if.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b actual %0b (tag %h)",
                   $time, want.hit, res_if.hit, want.tag);
          errors++;
        end
        if (res_if.hit_tag !== want.tag) begin
          $display("%0t: tag mismatch, expected %h actual %h",
                   $time, want.tag, res_if.hit_tag);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- idling
  function automatic int idle_cycles();
    if (calm || squeeze) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Result side: random stalls plus one long hold-off to back the pipe up
  initial begin
    int stall;
    int hold;
    bit held;
    stall = 0;
    hold  = 0;
    held  = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sent >= 300) begin
        held = 1'b1;
        hold = 250;
      end
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else begin
        if (res_if.valid && res_if.ready) stall = idle_cycles();
        if (stall > 0) begin
          stall--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [3*AXIS_WIDTH-1:0] pack_ax(logic [AXIS_WIDTH-1:0] x,
                                                     logic [AXIS_WIDTH-1:0] y,
                                                     logic [AXIS_WIDTH-1:0] z);
    return {z, y, x};
  endfunction

  task automatic add_row(kind_e k, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                         logic [47:0] au, logic [47:0] av, logic [47:0] aw,
                         logic [30:0] hu, logic [30:0] hv, logic [30:0] hw,
                         logic [15:0] tag, bit typed = 1'b0, bit typed_hit = 1'b0);
    box_req_t r;
    r = '{k, cx, cy, cz, au, av, aw, hu, hv, hw, tag, typed, typed_hit};
    table_q = {table_q, r};
  endtask

  // Random axis: signed basis vector, diagonal, unit-ish or raw bits
  function automatic logic [3*AXIS_WIDTH-1:0] rand_axis();
    logic [AXIS_WIDTH-1:0] c[3];
    int                    k;
    c = '{default: '0};
    k = $urandom_range(0, 2);
    case ($urandom_range(0, 3))
      0: c[k] = $urandom_range(0, 1) ? ONE_AX : -ONE_AX;
      1: begin
        c[k]         = $urandom_range(0, 1) ? DIAG : -DIAG;
        c[(k+1) % 3] = $urandom_range(0, 1) ? DIAG : -DIAG;
      end
      2: for (int i = 0; i < 3; i++)
           c[i] = AXIS_WIDTH'($signed($urandom_range(0, 2 * 16'h4000)) - 16'sh4000);
      default: return (3*AXIS_WIDTH)'({$urandom, $urandom});
    endcase
    return pack_ax(c[0], c[1], c[2]);
  endfunction

  function automatic logic [COORD_WIDTH-1:0] near(logic [COORD_WIDTH-1:0] base);
    return base + COORD_WIDTH'($urandom_range(0, 32'h80000)) - 32'h40000;
  endfunction

  function automatic box_req_t rand_req();
    box_req_t r;
    logic [3*AXIS_WIDTH-1:0] a[3];
    r.typed     = 1'b0;
    r.typed_hit = 1'b0;
    r.tag       = TAG_WIDTH'($urandom);
    r.kind      = ($urandom_range(0, 19) == 0) ? KIND_LOAD : KIND_TEST;
    if ($urandom_range(0, 9) < 7) begin
      // plausible box close to the reference
      r.cx = near(ref_c[0]);
      r.cy = near(ref_c[1]);
      r.cz = near(ref_c[2]);
      for (int i = 0; i < 3; i++) a[i] = rand_axis();
      r.au = a[0];
      r.av = a[1];
      r.aw = a[2];
      r.hu = (COORD_WIDTH-1)'($urandom_range(0, 32'h30000));
      r.hv = (COORD_WIDTH-1)'($urandom_range(0, 32'h30000));
      r.hw = (COORD_WIDTH-1)'($urandom_range(0, 32'h30000));
      if (r.kind == KIND_LOAD && $urandom_range(0, 3) == 0) begin
        r.cx = $urandom;
        r.cy = $urandom;
        r.cz = $urandom;
      end
    end else begin
      // raw noise across every bit
      r.cx = $urandom;
      r.cy = $urandom;
      r.cz = $urandom;
      r.au = (3*AXIS_WIDTH)'({$urandom, $urandom});
      r.av = (3*AXIS_WIDTH)'({$urandom, $urandom});
      r.aw = (3*AXIS_WIDTH)'({$urandom, $urandom});
      r.hu = (COORD_WIDTH-1)'($urandom);
      r.hv = (COORD_WIDTH-1)'($urandom);
      r.hw = (COORD_WIDTH-1)'($urandom);
    end
    return r;
  endfunction

  // Offer one request and hold it until taken; gap idles before it
  task automatic offer(box_req_t r, int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cur             <= r;
    req_if.kind     <= r.kind;
    req_if.center_x <= r.cx;
    req_if.center_y <= r.cy;
    req_if.center_z <= r.cz;
    req_if.axis_u   <= r.au;
    req_if.axis_v   <= r.av;
    req_if.axis_w   <= r.aw;
    req_if.half_u   <= r.hu;
    req_if.half_v   <= r.hv;
    req_if.half_w   <= r.hw;
    req_if.tag      <= r.tag;
    req_if.valid    <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [47:0] ix, iy, iz, rx, ry, rz, mn;
    box_req_t    r;
    ix = pack_ax(ONE_AX, '0, '0);
    iy = pack_ax('0, ONE_AX, '0);
    iz = pack_ax('0, '0, ONE_AX);
    rx = pack_ax(DIAG, DIAG, '0);
    ry = pack_ax(-DIAG, DIAG, '0);
    rz = iz;
    mn = pack_ax(16'h8000, 16'h8000, 16'h8000);

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = KIND_LOAD;
    req_if.center_x = '0;
    req_if.center_y = '0;
    req_if.center_z = '0;
    req_if.axis_u   = '0;
    req_if.axis_v   = '0;
    req_if.axis_w   = '0;
    req_if.half_u   = '0;
    req_if.half_v   = '0;
    req_if.half_w   = '0;
    req_if.tag      = '0;

    // Test before any load: zero box against zero box touches
    add_row(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1'b1, 1'b1);
    // Unit cube at the origin as reference; tag on a load is ignored
    add_row(KIND_LOAD, 0, 0, 0, ix, iy, iz, 31'h10000, 31'h10000, 31'h10000, 16'hABCD);
    add_row(KIND_TEST, 0, 0, 0, ix, iy, iz, 31'h10000, 31'h10000, 31'h10000,
            16'h0001, 1'b1, 1'b1);
    add_row(KIND_TEST, 32'hA0000, 0, 0, ix, iy, iz, 31'h10000, 31'h10000, 31'h10000,
            16'h0002, 1'b1, 1'b0);
    // Rotated target, shares the z axis so some cross products vanish
    add_row(KIND_TEST, 32'h18000, 0, 0, rx, ry, rz, 31'h10000, 31'h10000, 31'h10000, 16'h0003);
    add_row(KIND_TEST, 32'h28000, 32'h8000, 0, rx, ry, rz, 31'h8000, 31'h8000, 31'h8000,
            16'h0004);
    // Degenerate and non-unit axes
    add_row(KIND_TEST, 32'h30000, 0, 0, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
            16'h0005);
    add_row(KIND_TEST, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, mn, mn, mn,
            31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'h0006);
    add_row(KIND_TEST, 32'h80000000, 32'h80000000, 32'h80000000, 48'hFFFF_FFFF_FFFF,
            48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 16'h0007);
    // Reference at the extremes, saturation everywhere
    add_row(KIND_LOAD, 32'h80000000, 32'h80000000, 32'h80000000, mn, mn, mn,
            31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'h0);
    add_row(KIND_TEST, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, ix, iy, iz,
            31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'h8000);
    add_row(KIND_TEST, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, mn, mn, mn, 0, 0, 0, 16'h7FFF);
    add_row(KIND_TEST, 32'h80000000, 32'h80000000, 32'h80000000, mn, mn, mn, 0, 0, 0, 16'h0008);
    // Rotated reference, parallel and tilted targets
    add_row(KIND_LOAD, 32'h10000, 32'hFFFF0000, 0, rx, ry, rz, 31'h20000, 31'h8000,
            31'h10000, 16'h0);
    add_row(KIND_TEST, 32'h10000, 32'hFFFF0000, 0, rx, ry, rz, 31'h1, 31'h1, 31'h1, 16'h0009);
    add_row(KIND_TEST, 32'h40000, 0, 0, ix, iy, iz, 31'h10000, 31'h10000, 31'h10000, 16'h000A);
    add_row(KIND_TEST, 32'h30000, 32'h20000, 0, ix, iy, iz, 31'h8000, 31'h8000, 31'h8000,
            16'h000B);
    add_row(KIND_TEST, 32'h10000, 32'hFFFF0000, 32'h50000, iz, ix, iy, 31'h20000, 31'h8000,
            31'h30000, 16'h000C);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_q[n]) offer(table_q[n], idle_cycles());

    for (int n = 0; n < NUM_RANDOM; n++) begin
      squeeze = (sent >= 290) && (sent < 420);
      calm    = (n >= 700) && (n < 800);
      r = rand_req();
      offer(r, idle_cycles());
    end
    req_if.valid <= 1'b0;
    // let the last taken request reach the expectation queue
    @(posedge clk_i);

    wait (hit_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
